FILE: hw/rtl/rqs_pkg.sv
// rqs_pkg: shared types and constants for the ready queue scheduler.
// Holds policy codes, request codes, register indexes and sequencer states.
// No dependencies.
package rqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BURST_WIDTH_DEF = 16;

    // Fixed field widths of the command and result beats
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int BURST_IN_W = 16;
    localparam int QUANTUM_W = 16;
    localparam int REM_OUT_W = 16;
    localparam int OCC_W     = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd10;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_SJF  = 2'd1,
        POL_PRIO = 2'd2,
        POL_RR   = 2'd3
    } policy_t;

    typedef enum logic {
        REQ_ENQUEUE  = 1'b0,
        REQ_DISPATCH = 1'b1
    } req_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POLICY  = 1'b0,
        REG_QUANTUM = 1'b1
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_SCAN_END  = 7'b0000100,
        ST_RESOLVE   = 7'b0001000,
        ST_SHIFT     = 7'b0010000,
        ST_SHIFT_END = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

endpackage

FILE: hw/rtl/ready_queue_scheduler.sv
// Enqueue and dispatch on an empty queue give their result beat in the cycle after start.
// Dispatch scans slots (all n queued for SJF and priority, the head only for FIFO and round
// robin), then shifts each entry behind the chosen slot one place toward the head,
// through the one-read-port entry memory. No stalls: one command at a time.
// busy is high only while a dispatch walks the queue, up to the cycle before done.
// Async active-low reset empties the queue, policy FIFO, quantum 10; entry memory not cleared.
//
// ready_queue_scheduler: ready queue with FIFO / SJF / priority / round robin dispatch.
// Depends on rqs_pkg.
module ready_queue_scheduler
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BURST_WIDTH = BURST_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // command beat
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [ID_W-1:0]       task_id,
    input  logic [PRIO_W-1:0]     task_priority,
    input  logic [BURST_IN_W-1:0] burst_length,
    // result beat
    output logic                  done,
    output logic                  granted,
    output logic [ID_W-1:0]       grant_id,
    output logic [PRIO_W-1:0]     grant_priority,
    output logic [REM_OUT_W-1:0]  remaining_after,
    output logic                  burst_done,
    output logic                  queue_empty,
    output logic                  overflow,
    output logic [OCC_W-1:0]      occupancy
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + PRIO_W + BURST_WIDTH;
    localparam int CMP_W   = (BURST_WIDTH > PRIO_W) ? BURST_WIDTH : PRIO_W;
    localparam int SUB_W   = ((BURST_WIDTH > QUANTUM_W) ? BURST_WIDTH : QUANTUM_W) + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // Entry layout: {id, priority, burst}
    localparam int BURST_LO = 0;
    localparam int PRIO_LO  = BURST_WIDTH;
    localparam int ID_LO    = BURST_WIDTH + PRIO_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    policy_t                policy_reg;
    logic [QUANTUM_W-1:0]   quantum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FIFO;
            quantum_reg <= QUANTUM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_POLICY:  policy_reg  <= policy_t'(cfg_wdata[1:0]);
                REG_QUANTUM: quantum_reg <= cfg_wdata[QUANTUM_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and walk state
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       walk_idx_reg, walk_idx_next;   // read address during scan/shift
    logic [IDX_W-1:0]       scan_last_reg, scan_last_next;
    logic                   pend_v_reg, pend_v_next;       // read data valid this cycle
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;   // slot that read data came from
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [PRIO_W-1:0]      best_prio_reg, best_prio_next;
    logic [BURST_WIDTH-1:0] best_burst_reg, best_burst_next;
    logic [BURST_WIDTH-1:0] rem_reg, rem_next;
    logic                   requeue_reg, requeue_next;

    // result registers
    logic                   done_reg, done_next;
    logic                   granted_reg, granted_next;
    logic [ID_W-1:0]        grant_id_reg, grant_id_next;
    logic [PRIO_W-1:0]      grant_prio_reg, grant_prio_next;
    logic [REM_OUT_W-1:0]   rem_out_reg, rem_out_next;
    logic                   burst_done_reg, burst_done_next;
    logic                   empty_reg, empty_next;
    logic                   ovf_reg, ovf_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;

    // entry memory: one write port, one registered read port
    logic [ENTRY_W-1:0]     entry_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[mem_raddr];
    end

    // fields of the entry just read
    logic [ID_W-1:0]        cur_id;
    logic [PRIO_W-1:0]      cur_prio;
    logic [BURST_WIDTH-1:0] cur_burst;

    assign cur_id    = rd_data_reg[ID_LO +: ID_W];
    assign cur_prio  = rd_data_reg[PRIO_LO +: PRIO_W];
    assign cur_burst = rd_data_reg[BURST_LO +: BURST_WIDTH];

    // ------------------------------------------------------------------
    // Shared compare unit: "a > b", operands picked by policy
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt;

    always_comb
    begin
        unique case (policy_reg)
            POL_SJF:
            begin
                cmp_a = CMP_W'(best_burst_reg);
                cmp_b = CMP_W'(cur_burst);
            end
            POL_PRIO:
            begin
                cmp_a = CMP_W'(cur_prio);
                cmp_b = CMP_W'(best_prio_reg);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_gt = (cmp_a > cmp_b);

    // Round robin remainder, saturating at zero
    logic [SUB_W-1:0]       rr_diff;
    logic [BURST_WIDTH-1:0] rr_rem;

    assign rr_diff = SUB_W'(best_burst_reg) - SUB_W'(quantum_reg);
    assign rr_rem  = rr_diff[SUB_W-1] ? '0 : rr_diff[BURST_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    logic               accept;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   last_idx;
    logic               take_cur;

    assign accept   = start && (state_reg == ST_IDLE);
    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];
    // first slot always seeds the best; later slots replace on a strict win
    assign take_cur = (pend_idx_reg == '0) || cmp_gt;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        scan_last_next  = scan_last_reg;
        pend_v_next     = 1'b0;
        pend_idx_next   = walk_idx_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        best_prio_next  = best_prio_reg;
        best_burst_next = best_burst_reg;
        rem_next        = rem_reg;
        requeue_next    = requeue_reg;

        done_next       = 1'b0;
        granted_next    = granted_reg;
        grant_id_next   = grant_id_reg;
        grant_prio_next = grant_prio_reg;
        rem_out_next    = rem_out_reg;
        burst_done_next = burst_done_reg;
        empty_next      = empty_reg;
        ovf_next        = ovf_reg;
        occ_next        = occ_reg;

        mem_raddr = walk_idx_reg;
        mem_we    = 1'b0;
        mem_waddr = pend_idx_reg - IDX_W'(1);
        mem_wdata = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    granted_next    = 1'b0;
                    grant_id_next   = '0;
                    grant_prio_next = '0;
                    rem_out_next    = '0;
                    burst_done_next = 1'b0;
                    ovf_next        = 1'b0;
                    if (req_t'(req_type) == REQ_ENQUEUE)
                    begin
                        done_next = 1'b1;
                        if (count_reg >= FULL_CNT)
                        begin
                            ovf_next   = 1'b1;
                            empty_next = (count_reg == '0);
                            occ_next   = OCC_W'(count_reg);
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            mem_wdata  = {task_id, task_priority,
                                          BURST_WIDTH'(burst_length)};
                            count_next = count_reg + CNT_W'(1);
                            empty_next = 1'b0;
                            occ_next   = OCC_W'(count_reg + CNT_W'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next  = 1'b1;
                        empty_next = 1'b1;
                        occ_next   = '0;
                    end
                    else
                    begin
                        // only SJF and priority need the whole queue
                        walk_idx_next  = '0;
                        scan_last_next = ((policy_reg == POL_SJF) ||
                                          (policy_reg == POL_PRIO)) ? last_idx : '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_raddr     = walk_idx_reg;
                pend_v_next   = 1'b1;
                pend_idx_next = walk_idx_reg;
                if (pend_v_reg && take_cur)
                begin
                    best_idx_next   = pend_idx_reg;
                    best_id_next    = cur_id;
                    best_prio_next  = cur_prio;
                    best_burst_next = cur_burst;
                end
                if (walk_idx_reg == scan_last_reg)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end

            ST_SCAN_END:
            begin
                if (take_cur)
                begin
                    best_idx_next   = pend_idx_reg;
                    best_id_next    = cur_id;
                    best_prio_next  = cur_prio;
                    best_burst_next = cur_burst;
                end
                state_next = ST_RESOLVE;
            end

            ST_RESOLVE:
            begin
                rem_next     = rr_rem;
                requeue_next = (policy_reg == POL_RR) && (rr_rem != '0);
                if (best_idx_reg != last_idx)
                begin
                    walk_idx_next = best_idx_reg + IDX_W'(1);
                    state_next    = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_SHIFT:
            begin
                // read slot i+1 now, write it into slot i in the next cycle
                mem_raddr     = walk_idx_reg;
                pend_v_next   = 1'b1;
                pend_idx_next = walk_idx_reg;
                mem_we        = pend_v_reg;
                if (walk_idx_reg == last_idx)
                begin
                    state_next = ST_SHIFT_END;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end

            ST_SHIFT_END:
            begin
                mem_we     = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                granted_next    = 1'b1;
                grant_id_next   = best_id_reg;
                grant_prio_next = best_prio_reg;
                ovf_next        = 1'b0;
                done_next       = 1'b1;
                if (requeue_reg)
                begin
                    // task rejoins at the tail; occupancy unchanged
                    mem_we          = 1'b1;
                    mem_waddr       = last_idx;
                    mem_wdata       = {best_id_reg, best_prio_reg, rem_reg};
                    rem_out_next    = REM_OUT_W'(rem_reg);
                    burst_done_next = 1'b0;
                    empty_next      = 1'b0;
                    occ_next        = OCC_W'(count_reg);
                end
                else
                begin
                    count_next      = count_m1;
                    rem_out_next    = '0;
                    burst_done_next = 1'b1;
                    empty_next      = (count_m1 == '0);
                    occ_next        = OCC_W'(count_m1);
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pend_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_v_reg <= pend_v_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        walk_idx_reg   <= walk_idx_next;
        scan_last_reg  <= scan_last_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        best_prio_reg  <= best_prio_next;
        best_burst_reg <= best_burst_next;
        rem_reg        <= rem_next;
        requeue_reg    <= requeue_next;
        granted_reg    <= granted_next;
        grant_id_reg   <= grant_id_next;
        grant_prio_reg <= grant_prio_next;
        rem_out_reg    <= rem_out_next;
        burst_done_reg <= burst_done_next;
        empty_reg      <= empty_next;
        ovf_reg        <= ovf_next;
        occ_reg        <= occ_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign granted         = granted_reg;
    assign grant_id        = grant_id_reg;
    assign grant_priority  = grant_prio_reg;
    assign remaining_after = rem_out_reg;
    assign burst_done      = burst_done_reg;
    assign queue_empty     = empty_reg;
    assign overflow        = ovf_reg;
    assign occupancy       = occ_reg;

`ifndef SYNTHESIS
    // result beat never overlaps a command still in flight
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    // enqueue is answered in the next cycle
    a_enq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_ENQUEUE)) |=> (done && !busy))
        else $error("enqueue result missing");

    // dispatch on a non-empty queue starts the walk
    a_disp_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_DISPATCH) && (count_reg != '0))
            |=> (busy && !done))
        else $error("dispatch did not start scan");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: command-beat stimulus and a queue-tracking scoreboard for ready_queue_scheduler.
// Depends on rqs_pkg (widths, policy/request/register codes) and the RTL top.
module testbench;
    import rqs_pkg::*;

    localparam int QDEPTH    = QUEUE_DEPTH_DEF;

    // One queued task as the scheduler stores it (BURST_WIDTH equals the port width).
    typedef struct {
        logic [ID_W-1:0]       id;
        logic [PRIO_W-1:0]     prio;
        logic [BURST_IN_W-1:0] burst;
    } ready_task_t;

    // One result beat.
    typedef struct {
        logic                 granted;
        logic [ID_W-1:0]      grant_id;
        logic [PRIO_W-1:0]    grant_priority;
        logic [REM_OUT_W-1:0] remaining_after;
        logic                 burst_done;
        logic                 queue_empty;
        logic                 overflow;
        logic [OCC_W-1:0]     occupancy;
    } grant_beat_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the ready queue and the two registers, turns
    // every accepted command into the grant beat it must produce, and
    // compares result beats against those grants in order.
    // ------------------------------------------------------------------
    class grant_scoreboard;
        ready_task_t          ready_q[$];
        grant_beat_t          pending[$];
        policy_t              policy;
        logic [QUANTUM_W-1:0] quantum;
        int                   errors;

        function new();
            policy  = POL_FIFO;
            quantum = QUANTUM_RST;
            errors  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_POLICY)
                policy = policy_t'(data[1:0]);
            else
                quantum = data[QUANTUM_W-1:0];
        endfunction

        function void note_command(req_t req, ready_task_t offered);
            grant_beat_t g;
            ready_task_t head;
            int          pick;
            int          i;
            g = '{default: '0};
            if (req == REQ_ENQUEUE) begin
                if (ready_q.size() >= QDEPTH)
                    g.overflow = 1'b1;
                else
                    ready_q.push_back(offered);
            end
            else if (ready_q.size() > 0) begin
                g.granted = 1'b1;
                if (policy == POL_RR) begin
                    // head runs one slice; requeued at the tail unless used up
                    head = ready_q.pop_front();
                    g.grant_id       = head.id;
                    g.grant_priority = head.prio;
                    if (head.burst > quantum) begin
                        head.burst        = head.burst - quantum;
                        g.remaining_after = head.burst;
                        ready_q.push_back(head);
                    end
                    else
                        g.burst_done = 1'b1;
                end
                else begin
                    // strict compares: ties stay with the earliest arrival
                    pick = 0;
                    for (i = 1; i < ready_q.size(); i++) begin
                        if (policy == POL_SJF && ready_q[i].burst < ready_q[pick].burst)
                            pick = i;
                        if (policy == POL_PRIO && ready_q[i].prio > ready_q[pick].prio)
                            pick = i;
                    end
                    g.grant_id       = ready_q[pick].id;
                    g.grant_priority = ready_q[pick].prio;
                    g.burst_done     = 1'b1;
                    ready_q.delete(pick);
                end
            end
            g.queue_empty = (ready_q.size() == 0);
            g.occupancy   = OCC_W'(ready_q.size());
            pending.push_back(g);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(grant_beat_t got);
            grant_beat_t want;
            if (pending.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("granted",         32'(want.granted),        32'(got.granted));
            compare_field("grant_id",        32'(want.grant_id),       32'(got.grant_id));
            compare_field("grant_priority",  32'(want.grant_priority),
                          32'(got.grant_priority));
            compare_field("remaining_after", 32'(want.remaining_after),
                          32'(got.remaining_after));
            compare_field("burst_done",      32'(want.burst_done),     32'(got.burst_done));
            compare_field("queue_empty",     32'(want.queue_empty),    32'(got.queue_empty));
            compare_field("overflow",        32'(want.overflow),       32'(got.overflow));
            compare_field("occupancy",       32'(want.occupancy),      32'(got.occupancy));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs; every input is known from time zero.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  start         = 1'b0;
    logic                  req_type      = REQ_ENQUEUE;
    logic [ID_W-1:0]       task_id       = '0;
    logic [PRIO_W-1:0]     task_priority = '0;
    logic [BURST_IN_W-1:0] burst_length  = '0;

    logic                  busy;
    logic                  done;
    logic                  granted;
    logic [ID_W-1:0]       grant_id;
    logic [PRIO_W-1:0]     grant_priority;
    logic [REM_OUT_W-1:0]  remaining_after;
    logic                  burst_done;
    logic                  queue_empty;
    logic                  overflow;
    logic [OCC_W-1:0]      occupancy;

    always #4 clk = ~clk;

    ready_queue_scheduler DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .task_id         (task_id),
        .task_priority   (task_priority),
        .burst_length    (burst_length),
        .done            (done),
        .granted         (granted),
        .grant_id        (grant_id),
        .grant_priority  (grant_priority),
        .remaining_after (remaining_after),
        .burst_done      (burst_done),
        .queue_empty     (queue_empty),
        .overflow        (overflow),
        .occupancy       (occupancy)
    );

    grant_scoreboard sb = new();

    // ------------------------------------------------------------------
    // Monitor. Inputs change only by NBA at the clock edge, so reading at
    // the edge sees the values the block itself sampled. A result beat is
    // checked before a command taken at the same edge is noted; order does
    // not matter anyway, since expectations are popped oldest first.
    // ------------------------------------------------------------------
    grant_beat_t seen_beat;
    ready_task_t taken_task;

    always @(posedge clk) begin
        if (rst_n) begin
            if (done) begin
                seen_beat.granted         = granted;
                seen_beat.grant_id        = grant_id;
                seen_beat.grant_priority  = grant_priority;
                seen_beat.remaining_after = remaining_after;
                seen_beat.burst_done      = burst_done;
                seen_beat.queue_empty     = queue_empty;
                seen_beat.overflow        = overflow;
                seen_beat.occupancy       = occupancy;
                sb.check_result(seen_beat);
            end
            if (start && !busy) begin
                taken_task.id    = task_id;
                taken_task.prio  = task_priority;
                taken_task.burst = burst_length;
                sb.note_command(req_t'(req_type), taken_task);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    bit start_on = 1'b0;   // value last scheduled on start
    int idle_pct = 0;      // chance per cycle that the sender leaves start low

    // Present one command beat and hold it until accepted (start high, busy
    // low at an edge). start is only raised when it is low, so back-to-back
    // beats never see a lower/raise pair within one time step.
    task automatic issue(req_t req, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                         logic [BURST_IN_W-1:0] burst);
        if (!start_on)
            start <= 1'b1;
        start_on      = 1'b1;
        req_type      <= req;
        task_id       <= id;
        task_priority <= prio;
        burst_length  <= burst;
        do
            @(posedge clk);
        while (busy);
        // beat taken at this edge; optionally go quiet for a while
        if ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            start_on  = 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Drop start and wait until every outstanding beat has been checked.
    // Every command yields exactly one result, so nothing is left running.
    task automatic drain();
        if (start_on) begin
            start    <= 1'b0;
            start_on  = 1'b0;
        end
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Register write; only called while the block is drained.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Random command. Bursts lean toward a few quanta so round robin retires
    // tasks, with zero, all-ones and full-range values mixed in. Priorities
    // and bursts are sometimes squeezed into tiny ranges to force ties.
    task automatic random_item(int enq_pct, int burst_span);
        int                    sel;
        logic [PRIO_W-1:0]     prio;
        logic [BURST_IN_W-1:0] burst;
        sel = $urandom_range(19);
        if (sel == 0)
            burst = '0;
        else if (sel == 1)
            burst = '1;
        else if (sel < 7)
            burst = BURST_IN_W'($urandom);
        else if (sel < 10)
            burst = BURST_IN_W'($urandom_range(3, 1));
        else
            burst = BURST_IN_W'($urandom_range(burst_span, 1));
        if ($urandom_range(1))
            prio = PRIO_W'($urandom);
        else
            prio = PRIO_W'($urandom_range(3));
        issue(($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_DISPATCH,
              ID_W'($urandom), prio, burst);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int                   ph;
        int                   span;
        int                   enq_pct;
        logic [QUANTUM_W-1:0] q;
        policy_t              pol;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values first (FIFO, quantum 10).
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // empty queue
        issue(REQ_ENQUEUE,  8'h00, 8'h00, 16'h0000);
        issue(REQ_ENQUEUE,  8'hFF, 8'hFF, 16'hFFFF);
        issue(REQ_ENQUEUE,  8'hA5, 8'h5A, 16'd1);
        issue(REQ_ENQUEUE,  8'h5A, 8'hA5, 16'd25);
        issue(REQ_ENQUEUE,  8'h3C, 8'hFF, 16'd1);       // ties on burst and priority
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // FIFO head
        drain();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_SJF));
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // shortest, earliest of the tie
        drain();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_PRIO));
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // highest, earliest of the tie
        drain();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_RR));
        repeat (4) issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);  // requeue, retire, drain out
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // empty under round robin
        issue(REQ_ENQUEUE,  8'h11, 8'h22, 16'd0);       // zero burst retires at once
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);
        drain();
        write_reg(REG_QUANTUM, 16'd0);
        issue(REQ_ENQUEUE,  8'h33, 8'h44, 16'd7);
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // zero quantum: requeued as is
        drain();
        write_reg(REG_QUANTUM, 16'hFFFF);
        issue(REQ_DISPATCH, 8'h00, 8'h00, 16'd0);       // huge quantum retires it

        // Random phases: every policy four times, round robin with a mid
        // quantum, then 1, all-ones and zero. The enqueue mix swings so the
        // queue fills past full (overflow) and also runs dry.
        for (ph = 0; ph < 16; ph++) begin
            drain();
            pol = policy_t'(ph % 4);
            if (pol == POL_RR) begin
                case (ph / 4)
                    0:       q = QUANTUM_W'($urandom_range(200, 5));
                    1:       q = 16'd1;
                    2:       q = 16'hFFFF;
                    default: q = 16'd0;
                endcase
            end
            else
                q = QUANTUM_W'($urandom_range(300, 2));
            write_reg(REG_POLICY, CFG_DATA_W'(pol));
            write_reg(REG_QUANTUM, q);
            span    = (q == 0) ? 50 : ((int'(q) * 4 > 65535) ? 65535 : int'(q) * 4);
            enq_pct = 65 - 15 * (ph % 3);
            case ((ph + ph / 4) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 56;
                default: idle_pct = 26;
            endcase
            repeat (112) random_item(enq_pct, span);
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $error("%0d result beats never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit: well above the slowest legal run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rqs_pkg.sv
hw/rtl/ready_queue_scheduler.sv
bench/testbench.sv
